// File: hw/rtl/ct2f_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct2f_pkg
// Shared types, codes and constants for the Type2 charstring flattener.
// ----------------------------------------------------------------------------
package ct2f_pkg;

   localparam int MaxOperandsDefault = 48;

   // input item kinds
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_INT   = 3'd1;
   localparam logic [2:0] OP_REAL  = 3'd2;
   localparam logic [2:0] OP_OPER  = 3'd3;
   localparam logic [2:0] OP_CALL  = 3'd4;
   localparam logic [2:0] OP_MASK  = 3'd5;

   // operator codes with special handling
   localparam logic [11:0] OPC_HSTEM    = 12'd1;
   localparam logic [11:0] OPC_VSTEM    = 12'd3;
   localparam logic [11:0] OPC_HSTEMHM  = 12'd18;
   localparam logic [11:0] OPC_HINTMASK = 12'd19;
   localparam logic [11:0] OPC_CNTRMASK = 12'd20;
   localparam logic [11:0] OPC_VSTEMHM  = 12'd23;
   localparam logic [3:0]  OPC_ESC_PAGE = 4'hc;

   // encoding bytes
   localparam logic [7:0] BYTE_ESCAPE    = 8'd12;
   localparam logic [7:0] BYTE_DROP      = 8'h12;
   localparam logic [7:0] BYTE_SHORTINT  = 8'd28;
   localparam logic [7:0] BYTE_REAL      = 8'hff;
   localparam logic [7:0] BYTE_SMALL_OFS = 8'd139;
   localparam logic [7:0] BYTE_POS_BASE  = 8'd247;
   localparam logic [7:0] BYTE_NEG_BASE  = 8'd251;

   // result selection
   localparam logic [2:0] SEL_ERROR    = 3'd0;
   localparam logic [2:0] SEL_DROP     = 3'd1;
   localparam logic [2:0] SEL_MASK     = 3'd2;
   localparam logic [2:0] SEL_OPERAND  = 3'd3;
   localparam logic [2:0] SEL_OPERATOR = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [11:0]        operator_code;
      logic [5:0]         arg_count;
      logic [7:0]         mask_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [7:0] out_byte4;
      logic [2:0] byte_count;
      logic       last;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic       clear_glyph;
      logic       push;
      logic       clear_mask;
      logic       stem_add;
      logic       latch_op;
      logic       latch_call;
      logic       start_read;
      logic       next_read;
      logic       clear_fill;
      logic       dec_mask;
      logic       open_mask;
      logic       emit;
      logic [2:0] emit_sel;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic fill_one;
      logic fill_full;
      logic mask_pending;
      logic at_last;
      logic enc_bad;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/ct2f_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct2f_ctrl
// Sequencer: decodes input items and walks operand flushes.
// ----------------------------------------------------------------------------
module ct2f_ctrl
   import ct2f_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_op,
   output logic            req_stall,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_OPER = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       is_call_ff, is_call_in;

   assign req_stall = (state_ff != ST_IDLE) || !stat.out_free;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      is_call_in = is_call_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.out_free) begin
               unique case (req_op) inside
                  OP_START: cmd.clear_glyph = 1'b1;
                  OP_INT, OP_REAL: begin
                     cmd.clear_mask = 1'b1;
                     if (stat.fill_full) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = SEL_ERROR;
                        cmd.emit_last = 1'b1;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  OP_OPER: begin
                     cmd.clear_mask = 1'b1;
                     cmd.stem_add   = 1'b1;
                     cmd.latch_op   = 1'b1;
                     is_call_in     = 1'b0;
                     if (stat.fill_zero) begin
                        state_in = ST_OPER;
                     end else begin
                        cmd.start_read = 1'b1;
                        state_in       = ST_LOAD;
                     end
                  end
                  OP_CALL: begin
                     cmd.clear_mask = 1'b1;
                     if (stat.fill_zero) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = SEL_DROP;
                        cmd.emit_last = 1'b1;
                     end else if (stat.fill_one) begin
                        cmd.clear_fill = 1'b1;
                     end else begin
                        cmd.latch_op   = 1'b1;
                        cmd.latch_call = 1'b1;
                        cmd.start_read = 1'b1;
                        is_call_in     = 1'b1;
                        state_in       = ST_LOAD;
                     end
                  end
                  OP_MASK: begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     if (stat.mask_pending) begin
                        cmd.emit_sel = SEL_MASK;
                        cmd.dec_mask = 1'b1;
                     end else begin
                        cmd.emit_sel = SEL_ERROR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.enc_bad) begin
                  // out-of-range integer abandons the rest of the token
                  cmd.emit_sel   = SEL_ERROR;
                  cmd.emit_last  = 1'b1;
                  cmd.clear_fill = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.emit_sel  = SEL_OPERAND;
                  cmd.emit_last = is_call_ff && stat.at_last;
                  if (stat.at_last) begin
                     cmd.clear_fill = 1'b1;
                     state_in       = is_call_ff ? ST_IDLE : ST_OPER;
                  end else begin
                     cmd.next_read = 1'b1;
                     state_in      = ST_LOAD;
                  end
               end
            end
         end
         ST_OPER: begin
            if (stat.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_sel   = SEL_OPERATOR;
               cmd.emit_last  = 1'b1;
               cmd.open_mask  = 1'b1;
               cmd.clear_fill = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         is_call_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         is_call_ff <= is_call_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ct2f_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct2f_dpath
// Operand buffer, number encoder, stem and mask counters, result register.
// ----------------------------------------------------------------------------
module ct2f_dpath
   import ct2f_pkg::*;
#(
   parameter int MAX_OPERANDS = MaxOperandsDefault
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_payload,
   input  wire logic    rsp_stall,
   output logic         rsp_valid,
   output rsp_type      rsp_payload,
   input  wire cmd_type cmd,
   output stat_type     stat
);

   localparam int FILL_W = $clog2(MAX_OPERANDS + 1);
   localparam int IDX_W  = (MAX_OPERANDS > 1) ? $clog2(MAX_OPERANDS) : 1;

   logic [32:0]       store_mem [MAX_OPERANDS];
   logic [32:0]       rd_data_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  last_idx_ff;
   logic [15:0]       stem_ff, stem_in;
   logic [13:0]       mask_left_ff, mask_left_in;
   logic [11:0]       code_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              stem_code;
   logic [16:0]       stem_round;

   // encoder signals
   logic [31:0] ev;
   logic        e_real, e_small, e_pos2, e_neg2, e_short;
   logic [15:0] pos_u, neg_u;
   logic [7:0]  eb [5];
   logic [2:0]  en;

   // ---- operand store ----
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_mem[fill_ff[IDX_W-1:0]] <= {(req_payload.op == OP_REAL),
                                           req_payload.value};
      end
      rd_data_ff <= store_mem[rd_idx_ff];
   end

   // ---- counters ----
   always_comb begin
      stem_code = (req_payload.operator_code == OPC_HSTEM) ||
                  (req_payload.operator_code == OPC_VSTEM) ||
                  (req_payload.operator_code == OPC_HSTEMHM) ||
                  (req_payload.operator_code == OPC_HINTMASK) ||
                  (req_payload.operator_code == OPC_VSTEMHM);
      stem_round = {1'b0, stem_ff} + 17'd7;

      fill_in = fill_ff;
      if (cmd.clear_glyph || cmd.clear_fill) begin
         fill_in = '0;
      end else if (cmd.push) begin
         fill_in = fill_ff + FILL_W'(1);
      end

      stem_in = stem_ff;
      if (cmd.clear_glyph) begin
         stem_in = '0;
      end else if (cmd.stem_add && stem_code) begin
         stem_in = stem_ff + {11'd0, req_payload.arg_count[5:1]};
      end

      mask_left_in = mask_left_ff;
      if (cmd.clear_glyph || cmd.clear_mask) begin
         mask_left_in = '0;
      end else if (cmd.dec_mask) begin
         mask_left_in = mask_left_ff - 14'd1;
      end else if (cmd.open_mask &&
                   (code_ff == OPC_HINTMASK || code_ff == OPC_CNTRMASK)) begin
         mask_left_in = stem_round[16:3];
      end

      rd_idx_in = rd_idx_ff;
      if (cmd.start_read) begin
         rd_idx_in = '0;
      end else if (cmd.next_read) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         stem_ff      <= '0;
         mask_left_ff <= '0;
         rd_idx_ff    <= '0;
      end else begin
         fill_ff      <= fill_in;
         stem_ff      <= stem_in;
         mask_left_ff <= mask_left_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_op) begin
         code_ff     <= req_payload.operator_code;
         // a call drops its index operand, the last one buffered
         last_idx_ff <= cmd.latch_call ? IDX_W'(fill_ff - FILL_W'(2))
                                       : IDX_W'(fill_ff - FILL_W'(1));
      end
   end

   // ---- number encoder ----
   always_comb begin
      ev      = rd_data_ff[31:0];
      e_real  = rd_data_ff[32];
      e_small = ($signed(ev) >= -32'sd107) && ($signed(ev) <= 32'sd107);
      e_pos2  = ($signed(ev) >= 32'sd108) && ($signed(ev) <= 32'sd1131);
      e_neg2  = ($signed(ev) >= -32'sd1131) && ($signed(ev) <= -32'sd108);
      e_short = ($signed(ev) >= -32'sd32768) && ($signed(ev) <= 32'sd32767);
      pos_u   = ev[15:0] - 16'd108;
      neg_u   = (~ev[15:0]) + 16'd1 - 16'd108;
      for (int i = 0; i < 5; i++) begin
         eb[i] = 8'd0;
      end
      en = 3'd0;
      if (e_real) begin
         eb[0] = BYTE_REAL;
         eb[1] = ev[31:24];
         eb[2] = ev[23:16];
         eb[3] = ev[15:8];
         eb[4] = ev[7:0];
         en    = 3'd5;
      end else if (e_small) begin
         eb[0] = ev[7:0] + BYTE_SMALL_OFS;
         en    = 3'd1;
      end else if (e_pos2) begin
         eb[0] = BYTE_POS_BASE + {6'd0, pos_u[9:8]};
         eb[1] = pos_u[7:0];
         en    = 3'd2;
      end else if (e_neg2) begin
         eb[0] = BYTE_NEG_BASE + {6'd0, neg_u[9:8]};
         eb[1] = neg_u[7:0];
         en    = 3'd2;
      end else if (e_short) begin
         eb[0] = BYTE_SHORTINT;
         eb[1] = ev[15:8];
         eb[2] = ev[7:0];
         en    = 3'd3;
      end
   end

   // ---- result register ----
   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = cmd.emit_last;
         case (cmd.emit_sel)
            SEL_ERROR: rsp_in.error = 1'b1;
            SEL_DROP: begin
               rsp_in.out_byte0  = BYTE_ESCAPE;
               rsp_in.out_byte1  = BYTE_DROP;
               rsp_in.byte_count = 3'd2;
            end
            SEL_MASK: begin
               rsp_in.out_byte0  = req_payload.mask_value;
               rsp_in.byte_count = 3'd1;
            end
            SEL_OPERAND: begin
               rsp_in.out_byte0  = eb[0];
               rsp_in.out_byte1  = eb[1];
               rsp_in.out_byte2  = eb[2];
               rsp_in.out_byte3  = eb[3];
               rsp_in.out_byte4  = eb[4];
               rsp_in.byte_count = en;
            end
            SEL_OPERATOR: begin
               if (code_ff[11:8] == OPC_ESC_PAGE) begin
                  rsp_in.out_byte0  = BYTE_ESCAPE;
                  rsp_in.out_byte1  = code_ff[7:0];
                  rsp_in.byte_count = 3'd2;
               end else begin
                  rsp_in.out_byte0  = code_ff[7:0];
                  rsp_in.byte_count = 3'd1;
               end
            end
            default: rsp_in.error = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      stat.fill_zero    = (fill_ff == '0);
      stat.fill_one     = (fill_ff == FILL_W'(1));
      stat.fill_full    = (fill_ff == FILL_W'(MAX_OPERANDS));
      stat.mask_pending = (mask_left_ff != '0);
      stat.at_last      = (rd_idx_ff == last_idx_ff);
      stat.enc_bad      = (en == 3'd0);
      stat.out_free     = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire

// File: hw/rtl/charstring_type2_flattener.sv
`default_nettype none
// ----------------------------------------------------------------------------
// charstring_type2_flattener
// Re-emits an interpreted Type2 charstring as bytes with subroutine calls
// removed.
//
// Input items arrive on req_valid / req_stall / req_payload, one result per
// emitted token leaves on rsp_valid / rsp_stall / rsp_payload; the final
// result caused by an item carries last. Items that produce no result are
// the start glyph, buffered operands and a call with one operand. Results
// come from a single output register: a result that needs no flush appears
// the cycle after its transfer, the first flushed operand after its buffer
// read (ST_LOAD) and encoding (ST_EMIT). An operator flushes its buffered
// operands, then emits its code; a call flushes all operands but its last.
// Each flushed operand gets a registered buffer read, then its encoding.
// While the block works through a flush it stalls the input; when rsp_stall
// is high the result register holds and the sequencer waits on it.
// Reset empties the operand buffer, the stem total and the mask window and
// drops any result in the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module charstring_type2_flattener
   import ct2f_pkg::*;
#(
   parameter int MAX_OPERANDS = MaxOperandsDefault
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   ct2f_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ct2f_dpath #(
      .MAX_OPERANDS (MAX_OPERANDS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
`default_nettype wire
